/* rtl/tll_pkg.sv */
// shared types and constants for the tiny language lexer
// token record, token kind codes and keyword spelling tables; no dependencies
`default_nettype none

package tll_pkg;

    // token kind codes
    localparam logic [4:0] KIND_IF     = 5'd0;
    localparam logic [4:0] KIND_ID     = 5'd8;
    localparam logic [4:0] KIND_NUM    = 5'd9;
    localparam logic [4:0] KIND_ASSIGN = 5'd10;
    localparam logic [4:0] KIND_PLUS   = 5'd11;
    localparam logic [4:0] KIND_MINUS  = 5'd12;
    localparam logic [4:0] KIND_TIMES  = 5'd13;
    localparam logic [4:0] KIND_OVER   = 5'd14;
    localparam logic [4:0] KIND_EQUAL  = 5'd15;
    localparam logic [4:0] KIND_LESS   = 5'd16;
    localparam logic [4:0] KIND_LPAREN = 5'd17;
    localparam logic [4:0] KIND_RPAREN = 5'd18;
    localparam logic [4:0] KIND_SEMI   = 5'd19;
    localparam logic [4:0] KIND_EOF    = 5'd20;
    localparam logic [4:0] KIND_ERROR  = 5'd21;

    localparam int KW_COUNT = 8;

    // keyword spelling, one character per position, zero padded
    localparam logic [7:0] KW_TEXT [KW_COUNT][8] = '{
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"t", "h", "e", "n", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "n", "d", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"r", "e", "p", "e", "a", "t", 8'h00, 8'h00},
        '{"u", "n", "t", "i", "l", 8'h00, 8'h00, 8'h00},
        '{"r", "e", "a", "d", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"w", "r", "i", "t", "e", 8'h00, 8'h00, 8'h00}
    };

    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd2, 3'd4, 3'd4, 3'd3, 3'd6, 3'd5, 3'd4, 3'd5
    };

    // one output token
    typedef struct packed {
        logic [4:0]  kind;
        logic [6:0]  len;
        logic [31:0] value;
        logic        ovf;
        logic        last;
    } token_t;

    // tokens caused by one accepted character
    typedef struct packed {
        logic [1:0] count;
        token_t     tok0;
        token_t     tok1;
    } scan_out_t;

endpackage

`default_nettype wire

/* rtl/tll_scan.sv */
// scanner state and per-character token logic
// depends on tll_pkg for token types, kind codes and keyword tables
`default_nettype none

module tll_scan
    import tll_pkg::*;
#(
    parameter int MAX_LEXEME_LEN = 64,
    parameter int NUMBER_WIDTH   = 32
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic [7:0] char_code,
    input  wire logic       end_of_input,
    output scan_out_t       result
);

    localparam int CW = $clog2(MAX_LEXEME_LEN + 1);
    localparam int LW = (CW > 7) ? CW : 7;
    localparam int VW = (NUMBER_WIDTH > 32) ? NUMBER_WIDTH : 32;

    localparam logic [2:0] MODE_START   = 3'd0;
    localparam logic [2:0] MODE_NUM     = 3'd1;
    localparam logic [2:0] MODE_ID      = 3'd2;
    localparam logic [2:0] MODE_ASSIGN  = 3'd3;
    localparam logic [2:0] MODE_COMMENT = 3'd4;

    localparam logic [NUMBER_WIDTH-1:0] NUM_MAX = {NUMBER_WIDTH{1'b1}};

    logic [2:0]              mode_reg, mode_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [NUMBER_WIDTH-1:0] acc_reg, acc_next;
    logic                    ovf_reg, ovf_next;
    logic [7:0]              cand_reg, cand_next;

    logic                    is_ws, is_digit, is_letter;
    logic [3:0]              digit;
    logic [NUMBER_WIDTH+3:0] acc_x10;
    logic [CW-1:0]           count_inc;
    logic                    op_hit;
    logic [4:0]              op_kind;
    logic                    first_valid, second_valid;
    token_t                  first_tok, second_tok;

    // keep the keywords that still match at this position
    function automatic logic [7:0] filter_kw(input logic [7:0] cand,
                                             input logic [CW-1:0] pos,
                                             input logic [7:0] c);
        logic [7:0] res;
        res = '0;
        for (int k = 0; k < KW_COUNT; k++) begin
            if (cand[k] && (pos < CW'(KW_LEN[k])) && (KW_TEXT[k][pos[2:0]] == c)) begin
                res[k] = 1'b1;
            end
        end
        return res;
    endfunction

    // first surviving keyword of exactly this length, else identifier
    function automatic logic [4:0] id_kind(input logic [7:0] cand,
                                           input logic [CW-1:0] len);
        logic [4:0] kind;
        kind = KIND_ID;
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            if (cand[k] && (len == CW'(KW_LEN[k]))) begin
                kind = KIND_IF + 5'(k);
            end
        end
        return kind;
    endfunction

    function automatic logic [6:0] len_field(input logic [CW-1:0] len);
        logic [LW-1:0] wide;
        wide = LW'(len);
        return wide[6:0];
    endfunction

    function automatic logic [31:0] value_field(input logic [NUMBER_WIDTH-1:0] v);
        logic [VW-1:0] wide;
        wide = VW'(v);
        return wide[31:0];
    endfunction

    function automatic token_t make_tok(input logic [4:0] kind, input logic [6:0] len);
        token_t t;
        t       = '0;
        t.kind  = kind;
        t.len   = len;
        return t;
    endfunction

    // character classes
    assign is_ws     = ((char_code >= 8'd9) && (char_code <= 8'd13)) || (char_code == " ");
    assign is_digit  = (char_code >= "0") && (char_code <= "9");
    assign is_letter = ((char_code >= "A") && (char_code <= "Z")) ||
                       ((char_code >= "a") && (char_code <= "z"));
    assign digit     = 4'(char_code - "0");

    // accumulator times ten plus digit, by shift and add
    assign acc_x10 = ((NUMBER_WIDTH+4)'(acc_reg) << 3) + ((NUMBER_WIDTH+4)'(acc_reg) << 1)
                   + (NUMBER_WIDTH+4)'(digit);

    assign count_inc = (count_reg < CW'(MAX_LEXEME_LEN)) ? CW'(count_reg + 1'b1) : count_reg;

    // single character operators
    always_comb
    begin
        op_hit  = 1'b1;
        op_kind = KIND_ERROR;
        unique case (char_code)
            "+":     op_kind = KIND_PLUS;
            "-":     op_kind = KIND_MINUS;
            "*":     op_kind = KIND_TIMES;
            "/":     op_kind = KIND_OVER;
            "=":     op_kind = KIND_EQUAL;
            "<":     op_kind = KIND_LESS;
            "(":     op_kind = KIND_LPAREN;
            ")":     op_kind = KIND_RPAREN;
            ";":     op_kind = KIND_SEMI;
            default: op_hit  = 1'b0;
        endcase
    end

    // next state and tokens: first is a flushed or closing token, second a new one
    always_comb
    begin
        mode_next    = mode_reg;
        count_next   = count_reg;
        acc_next     = acc_reg;
        ovf_next     = ovf_reg;
        cand_next    = cand_reg;
        first_valid  = 1'b0;
        second_valid = 1'b0;
        first_tok    = '0;
        second_tok   = '0;

        if (end_of_input) begin
            if (mode_reg == MODE_ASSIGN) begin
                first_valid = 1'b1;
                first_tok   = make_tok(KIND_ERROR, 7'd1);
            end else if (mode_reg == MODE_NUM) begin
                first_valid     = 1'b1;
                first_tok       = make_tok(KIND_NUM, len_field(count_reg));
                first_tok.value = value_field(acc_reg);
                first_tok.ovf   = ovf_reg;
            end else if (mode_reg == MODE_ID) begin
                first_valid = 1'b1;
                first_tok   = make_tok(id_kind(cand_reg, count_reg), len_field(count_reg));
            end
            second_valid = 1'b1;
            second_tok   = make_tok(KIND_EOF, 7'd0);
            mode_next    = MODE_START;
            count_next   = '0;
            acc_next     = '0;
            ovf_next     = 1'b0;
            cand_next    = '1;
        end else if (mode_reg == MODE_COMMENT) begin
            if (char_code == "}") begin
                mode_next  = MODE_START;
                count_next = '0;
                acc_next   = '0;
                ovf_next   = 1'b0;
                cand_next  = '1;
            end
        end else if (mode_reg == MODE_ASSIGN) begin
            first_valid = 1'b1;
            first_tok   = make_tok((char_code == "=") ? KIND_ASSIGN : KIND_ERROR, 7'd2);
            mode_next   = MODE_START;
            count_next  = '0;
            acc_next    = '0;
            ovf_next    = 1'b0;
            cand_next   = '1;
        end else if ((mode_reg == MODE_NUM) && is_digit) begin
            if (acc_x10 > (NUMBER_WIDTH+4)'(NUM_MAX)) begin
                acc_next = NUM_MAX;
                ovf_next = 1'b1;
            end else begin
                acc_next = acc_x10[NUMBER_WIDTH-1:0];
            end
            count_next = count_inc;
        end else if ((mode_reg == MODE_ID) && is_letter) begin
            cand_next  = filter_kw(cand_reg, count_reg, char_code);
            count_next = count_inc;
        end else begin
            // flush a pending number or identifier
            if (mode_reg == MODE_NUM) begin
                first_valid     = 1'b1;
                first_tok       = make_tok(KIND_NUM, len_field(count_reg));
                first_tok.value = value_field(acc_reg);
                first_tok.ovf   = ovf_reg;
            end else if (mode_reg == MODE_ID) begin
                first_valid = 1'b1;
                first_tok   = make_tok(id_kind(cand_reg, count_reg), len_field(count_reg));
            end
            mode_next  = MODE_START;
            count_next = '0;
            acc_next   = '0;
            ovf_next   = 1'b0;
            cand_next  = '1;

            // rescan the character from start mode
            priority if (is_ws) begin
                mode_next = MODE_START;
            end else if (op_hit) begin
                second_valid = 1'b1;
                second_tok   = make_tok(op_kind, 7'd1);
            end else if (char_code == ":") begin
                mode_next  = MODE_ASSIGN;
                count_next = CW'(1);
            end else if (is_digit) begin
                mode_next  = MODE_NUM;
                count_next = CW'(1);
                acc_next   = NUMBER_WIDTH'(digit);
            end else if (is_letter) begin
                mode_next  = MODE_ID;
                count_next = CW'(1);
                cand_next  = filter_kw(8'hFF, '0, char_code);
            end else if (char_code == "{") begin
                mode_next = MODE_COMMENT;
            end else begin
                second_valid = 1'b1;
                second_tok   = make_tok(KIND_ERROR, 7'd1);
            end
        end
    end

    // pack the tokens in order and mark the final one
    always_comb
    begin
        result = '0;
        if (first_valid && second_valid) begin
            result.count     = 2'd2;
            result.tok0      = first_tok;
            result.tok1      = second_tok;
            result.tok1.last = 1'b1;
        end else if (first_valid) begin
            result.count     = 2'd1;
            result.tok0      = first_tok;
            result.tok0.last = 1'b1;
        end else if (second_valid) begin
            result.count     = 2'd1;
            result.tok0      = second_tok;
            result.tok0.last = 1'b1;
        end
    end

    // scanner state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg  <= MODE_START;
            count_reg <= '0;
            acc_reg   <= '0;
            ovf_reg   <= 1'b0;
            cand_reg  <= '1;
        end else if (accept) begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
            acc_reg   <= acc_next;
            ovf_reg   <= ovf_next;
            cand_reg  <= cand_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/tll_queue.sv */
// four-entry token queue, up to two writes and one read per cycle
// depends on tll_pkg for the token record types
`default_nettype none

module tll_queue
    import tll_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire scan_out_t push_data,
    output logic           room,
    output logic           head_valid,
    input  wire logic      pop,
    output token_t         head
);

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    token_t          mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PW:0]     fill_reg, fill_next;
    logic [1:0]      push_n;
    logic            do_pop;
    logic [PW-1:0]   wr_ptr_plus1;

    // room for the two tokens a character can cause
    assign room         = (fill_reg <= (PW+1)'(DEPTH - 2));
    assign head_valid   = (fill_reg != '0);
    assign head         = mem_reg[rd_ptr_reg];
    assign do_pop       = pop && head_valid;
    assign push_n       = push ? push_data.count : 2'd0;
    assign wr_ptr_plus1 = PW'(wr_ptr_reg + 1'b1);

    // pointer and fill updates
    always_comb
    begin
        wr_ptr_next = PW'(wr_ptr_reg + PW'(push_n));
        rd_ptr_next = do_pop ? PW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        fill_next   = (PW+1)'(fill_reg + (PW+1)'(push_n) - (PW+1)'(do_pop));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // token storage
    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push_data.tok0;
        end
        if (push_n == 2'd2) begin
            mem_reg[wr_ptr_plus1] <= push_data.tok1;
        end
    end

endmodule

`default_nettype wire

/* rtl/tiny_language_lexer.sv */
// tiny language lexer: one character per transaction in, tokens out
// a token is written into the output queue when the character that completes it is accepted
// throughput: one character per cycle while tokens drain; two-token characters
//   fill a four-entry output queue, and in_ready drops when it holds three or more
// reset: scanner returns to start mode with an empty lexeme and the queue empties
// depends on tll_pkg, tll_scan, tll_queue
`default_nettype none

module tiny_language_lexer
    import tll_pkg::*;
#(
    parameter int MAX_LEXEME_LEN = 64,
    parameter int NUMBER_WIDTH   = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  char_code,
    input  wire logic        end_of_input,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [4:0]       token_kind,
    output logic [6:0]       lexeme_length,
    output logic [31:0]      number_value,
    output logic             number_overflow,
    output logic             last
);

    logic      accept;
    logic      room;
    scan_out_t scan_result;
    token_t    head;

    assign in_ready = room;
    assign accept   = in_valid && room;

    // per-character scanner
    tll_scan #(
        .MAX_LEXEME_LEN (MAX_LEXEME_LEN),
        .NUMBER_WIDTH   (NUMBER_WIDTH)
    ) u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .char_code    (char_code),
        .end_of_input (end_of_input),
        .result       (scan_result)
    );

    // output token queue
    tll_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_data  (scan_result),
        .room       (room),
        .head_valid (out_valid),
        .pop        (out_ready),
        .head       (head)
    );

    assign token_kind      = head.kind;
    assign lexeme_length   = head.len;
    assign number_value    = head.value;
    assign number_overflow = head.ovf;
    assign last            = head.last;

endmodule

`default_nettype wire
